FILE: src/arm_rel_pkg.sv
// ----------------------------------------------------------------------------
// arm_rel_pkg: shared types and helpers for the ARM relocator
// Holds the status codes and the word rotate functions used by the rewrite
// logic and the immediate encoder.
// ----------------------------------------------------------------------------
package arm_rel_pkg;

  typedef enum logic [3:0] {
    ST_OK              = 4'd0,
    ST_BLX_ON_V4       = 4'd1,
    ST_BRANCH_RANGE    = 4'd2,
    ST_LDR_MODE        = 4'd3,
    ST_LDR_RANGE       = 4'd4,
    ST_ADR_UNENCODABLE = 4'd5,
    ST_LDM_PC          = 4'd6,
    ST_HALF_MODE       = 4'd7,
    ST_HALF_RANGE      = 4'd8,
    ST_COPRO_PC        = 4'd9
  } status_t;

  // Instruction class field, bits 27:25.
  localparam logic [2:0] GRP_MISC   = 3'b000;
  localparam logic [2:0] GRP_DPIMM  = 3'b001;
  localparam logic [2:0] GRP_LDRIMM = 3'b010;
  localparam logic [2:0] GRP_LDM    = 3'b100;
  localparam logic [2:0] GRP_BRANCH = 3'b101;
  localparam logic [2:0] GRP_COPRO  = 3'b110;

  localparam logic [6:0] BLX_PREFIX = 7'b1111101;
  localparam logic [3:0] OPC_ADD    = 4'b0100;
  localparam logic [3:0] OPC_SUB    = 4'b0010;
  localparam logic [3:0] REG_PC     = 4'hF;

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

endpackage

FILE: src/arm_rel_imm_enc.sv
// ----------------------------------------------------------------------------
// arm_rel_imm_enc: rotated 8-bit immediate encoder
// Finds the smallest rotate field that expresses a 32-bit value as an
// 8-bit constant rotated right by twice the field.
// ----------------------------------------------------------------------------
module arm_rel_imm_enc
  import arm_rel_pkg::*;
(
  input  logic [31:0] mag,
  output logic        found,
  output logic [3:0]  rot,
  output logic [7:0]  imm8
);

  logic [31:0] enc;

  // All sixteen windows are checked side by side; walking downward leaves
  // the smallest fitting rotation as the winner.
  always_comb begin
    found = 1'b0;
    rot   = '0;
    enc   = '0;
    for (int r = 15; r >= 0; r--) begin
      if ((mag & ~ror32(32'h0000_00FF, 5'(2 * r))) == 32'd0) begin
        found = 1'b1;
        rot   = 4'(r);
        enc   = rol32(mag, 5'(2 * r));
      end
    end
  end

  assign imm8 = enc[7:0];

endmodule

FILE: src/arm_rel_core.sv
// ----------------------------------------------------------------------------
// arm_rel_core: instruction decode and PC-relative field rewrite
// Works from the registered word and the address difference in both
// directions, producing the rewritten word and a status code.
// ----------------------------------------------------------------------------
module arm_rel_core
  import arm_rel_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] delta,   // old_addr - new_addr
  input  logic [31:0] ndelta,  // new_addr - old_addr
  input  logic        arm9_mode,
  output logic [31:0] new_instr,
  output status_t     status
);

  logic [2:0]  grp;
  logic        rn_pc;
  logic        bit_p, bit_u, bit_w;
  logic [31:0] br_off;
  logic [31:0] blx_d;
  logic [31:0] b_d;
  logic [31:0] b_w;
  logic [31:0] ldr_imm;
  logic [31:0] ldr_n, ldr_nn, ldr_mag;
  logic [31:0] hw_imm;
  logic [31:0] hw_n, hw_nn, hw_mag;
  logic [3:0]  adr_opc;
  logic        adr_add;
  logic [31:0] adr_val;
  logic [31:0] adr_n, adr_nn, adr_mag;
  logic        adr_neg;
  logic        enc_found;
  logic [3:0]  enc_rot;
  logic [7:0]  enc_imm8;
  logic        is_half;

  assign grp   = instr[27:25];
  assign rn_pc = (instr[19:16] == REG_PC);
  assign bit_p = instr[24];
  assign bit_u = instr[23];
  assign bit_w = instr[21];

  // Branch target arithmetic; the PC bias of +8 cancels for BLX and folds
  // into the constant for B/BL.
  assign br_off = {{6{instr[23]}}, instr[23:0], 2'b00};
  assign blx_d  = delta + br_off + {30'd0, instr[24], 1'b0};
  assign b_d    = delta + br_off + 32'd8;
  assign b_w    = {{2{b_d[31]}}, b_d[31:2]} - 32'd2;

  // Single data transfer with a 12-bit immediate.
  assign ldr_imm = {20'd0, instr[11:0]};
  assign ldr_n   = bit_u ? delta + ldr_imm : delta - ldr_imm;
  assign ldr_nn  = bit_u ? ndelta - ldr_imm : ndelta + ldr_imm;
  assign ldr_mag = ldr_n[31] ? ldr_nn : ldr_n;

  // Halfword transfer with a split 8-bit immediate.
  assign is_half = (instr[7] & instr[4]) & (instr[6:5] != 2'b00);
  assign hw_imm  = {24'd0, instr[11:8], instr[3:0]};
  assign hw_n    = bit_u ? delta + hw_imm : delta - hw_imm;
  assign hw_nn   = bit_u ? ndelta - hw_imm : ndelta + hw_imm;
  assign hw_mag  = hw_n[31] ? hw_nn : hw_n;

  // ADR as ADD/SUB with PC: the magnitude is formed from both difference
  // directions at once so no negate sits after the add.
  assign adr_opc = instr[24:21];
  assign adr_add = (adr_opc == OPC_ADD);
  assign adr_val = ror32({24'd0, instr[7:0]}, {instr[11:8], 1'b0});
  assign adr_n   = adr_add ? delta + adr_val : delta - adr_val;
  assign adr_nn  = adr_add ? ndelta - adr_val : ndelta + adr_val;
  assign adr_neg = adr_n[31];
  assign adr_mag = adr_neg ? adr_nn : adr_n;

  arm_rel_imm_enc u_imm_enc (
    .mag   (adr_mag),
    .found (enc_found),
    .rot   (enc_rot),
    .imm8  (enc_imm8)
  );

  always_comb begin
    new_instr = instr;
    status    = ST_OK;
    if (grp == GRP_BRANCH) begin
      if (instr[31:25] == BLX_PREFIX) begin
        if (!arm9_mode) begin
          status = ST_BLX_ON_V4;
        end else if (!((blx_d[31:25] == 7'h00) || (blx_d[31:25] == 7'h7F))) begin
          status = ST_BRANCH_RANGE;
        end else begin
          new_instr = {BLX_PREFIX, blx_d[1], blx_d[25:2]};
        end
      end else if (!((b_w[31:23] == 9'h000) || (b_w[31:23] == 9'h1FF))) begin
        status = ST_BRANCH_RANGE;
      end else begin
        new_instr = {instr[31:24], b_w[23:0]};
      end
    end else if (grp == GRP_LDRIMM && rn_pc) begin
      if (!bit_p || bit_w) begin
        status = ST_LDR_MODE;
      end else if (ldr_mag[31:12] != 20'd0) begin
        status = ST_LDR_RANGE;
      end else begin
        new_instr = {instr[31:24], ~ldr_n[31], instr[22:12], ldr_mag[11:0]};
      end
    end else if (grp == GRP_DPIMM && rn_pc
                 && (adr_opc == OPC_ADD || adr_opc == OPC_SUB)) begin
      if (!enc_found) begin
        status = ST_ADR_UNENCODABLE;
      end else begin
        new_instr = {instr[31:25], adr_neg ? OPC_SUB : OPC_ADD, instr[20:12],
                     enc_rot, enc_imm8};
      end
    end else if (grp == GRP_LDM && rn_pc) begin
      status = ST_LDM_PC;
    end else if (grp == GRP_MISC && is_half && rn_pc) begin
      if (!bit_p || bit_w || !instr[22]) begin
        status = ST_HALF_MODE;
      end else if (hw_mag[31:8] != 24'd0) begin
        status = ST_HALF_RANGE;
      end else begin
        new_instr = {instr[31:24], ~hw_n[31], instr[22:12], hw_mag[7:4],
                     instr[7:4], hw_mag[3:0]};
      end
    end else if (grp == GRP_COPRO && rn_pc) begin
      status = ST_COPRO_PC;
    end
  end

endmodule

FILE: src/arm_instruction_relocator.sv
// ----------------------------------------------------------------------------
// arm_instruction_relocator: ARM32 PC-relative instruction relocation
// Rewrites branch, literal load, ADR and halfword literal offsets so a moved
// instruction keeps its target, and reports cases it cannot rewrite.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid/in_ready) carries one instruction
// word with the address it was built for and the address it moves to. One
// result request per input leaves on the output channel (out_valid/out_ready)
// with the rewritten word and a status code; on any nonzero status the word
// comes back unchanged.
// The path is two register stages: an input register that also forms the
// address difference in both directions, then the decode, rewrite and
// immediate search feeding the output register. An accepted request passes
// from the input register to the output register as soon as that stage can
// load, and is presented from there. One request per cycle is sustained when
// the receiver keeps out_ready high. If the receiver stalls, the output
// register holds its result and the input register still takes one more
// request, so in_ready drops only when both stages are full.
// The APB register at byte address 0 holds arm9_mode in bit 0. Reset
// (synchronous, rst_n low) empties both stages and sets arm9_mode to 1.
// ----------------------------------------------------------------------------
module arm_instruction_relocator
  import arm_rel_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr,
  input  logic [31:0] in_old_addr,
  input  logic [31:0] in_new_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_new_instr,
  output logic [3:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        arm9_mode_r;
  logic        s1_valid_r;
  logic [31:0] s1_instr_r;
  logic [31:0] s1_delta_r;
  logic [31:0] s1_ndelta_r;
  logic        out_valid_r;
  logic [31:0] out_new_instr_r;
  status_t     out_status_r;
  logic        out_adv;
  logic        s1_move;
  logic        in_take;
  logic [31:0] core_instr;
  status_t     core_status;

  // The output stage can load whenever it is empty or being drained; the
  // input stage can load whenever it is empty or moving forward.
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_take  = in_valid && in_ready;

  // Configuration: one register, decoded on the word address bit.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, arm9_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm9_mode_r <= 1'b1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      arm9_mode_r <= pwdata[0];
    end
  end

  // Input stage. Only the address difference is kept, since the PC bias
  // cancels in every rewrite.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_instr_r  <= in_instr;
      s1_delta_r  <= in_old_addr - in_new_addr;
      s1_ndelta_r <= in_new_addr - in_old_addr;
    end
  end

  arm_rel_core u_core (
    .instr     (s1_instr_r),
    .delta     (s1_delta_r),
    .ndelta    (s1_ndelta_r),
    .arm9_mode (arm9_mode_r),
    .new_instr (core_instr),
    .status    (core_status)
  );

  // Output stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_new_instr_r <= core_instr;
      out_status_r    <= core_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_instr = out_new_instr_r;
  assign out_status    = out_status_r;

endmodule

FILE: src/arm_rel_checker.sv
// ----------------------------------------------------------------------------
// arm_rel_checker: port-level checks for the ARM relocator
// Watches the top-level ports for reset, stall, flow and register behavior.
// ----------------------------------------------------------------------------
module arm_rel_checker
  import arm_rel_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_instr,
  input logic [3:0]  out_status,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // No result may be presented right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented after reset");

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_instr)
                                && $stable(out_status))
    else $error("stalled result changed");

  // With the output stage empty the block must take a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Status codes stay inside the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_COPRO_PC)
    else $error("undefined status code");

  // The mode register reads back what was written.
  a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> prdata[0] == $past(pwdata[0]))
    else $error("mode register readback mismatch");

endmodule

bind arm_instruction_relocator arm_rel_checker u_arm_rel_checker (.*);
